// File: design/rvalu_pkg.sv
// Shared types and constants for the RV32I register ALU execute block.
// Holds the channel beat structs, the funct3 operation codes and decode constants.
// No dependencies.
`default_nettype none

package rvalu_pkg;

  localparam int unsigned RegCount    = 32;
  localparam int unsigned XLen        = 32;
  localparam int unsigned RegIdxWidth = 5;

  // funct7 value that selects SUB (register form) or SRA (either form).
  localparam logic [6:0] SubSraSel = 7'h20;

  typedef enum logic [2:0] {
    F3_ADD  = 3'd0,
    F3_SLL  = 3'd1,
    F3_SLT  = 3'd2,
    F3_SLTU = 3'd3,
    F3_XOR  = 3'd4,
    F3_SR   = 3'd5,
    F3_OR   = 3'd6,
    F3_AND  = 3'd7
  } alu_op_t;

  typedef enum logic {
    FORM_REG = 1'b0,
    FORM_IMM = 1'b1
  } form_t;

  typedef struct packed {
    logic        cmd;
    logic [4:0]  dest_reg;
    logic [2:0]  func3;
    logic [4:0]  src1_reg;
    logic [4:0]  src2_reg;
    logic [6:0]  func7;
    logic [11:0] imm12;
  } op_beat_t;

  typedef struct packed {
    logic [4:0]         write_index;
    logic signed [31:0] write_value;
  } res_beat_t;

  // Execute stage register: the instruction plus operand source selection.
  typedef struct packed {
    op_beat_t op;
    logic     vld1;
    logic     vld2;
    logic     byp1;
    logic     byp2;
  } exec_stage_t;

endpackage

`default_nettype wire

// File: design/rvalu_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Read returns the old contents when reading and writing one address in a cycle.
// No dependencies.
`default_nettype none

module rvalu_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: design/rv32i_register_alu_execute_top.sv
// Top level of the RV32I register ALU execute block: register file, ALU, result register.
// Depends on rvalu_pkg and rvalu_ram.
//
//   Channel   Direction  Handshake            Beat type
//   op        in         op_valid / op_stall   rvalu_pkg::op_beat_t
//   res       out        res_valid / res_stall rvalu_pkg::res_beat_t
//
// One instruction is accepted per cycle while op_stall is low; an accepted op beat passes
// through the execute stage register and then the result register, which presents its beat.
// The register file read ports are registered RAMs, so the operands arrive in the execute
// stage; the ALU result is written back from there and registered in the result register.
// A result written in the same cycle that a following instruction reads its sources is
// forwarded into that instruction's stage register.
// Reset clears the per-entry valid bits at once, so every register reads zero; there is
// no clearing pass. The op side stalls only while the execute stage is full and the
// result register holds a beat that is itself stalled.
`default_nettype none

module rv32i_register_alu_execute_top (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 op_valid,
  output logic                      op_stall,
  input  wire rvalu_pkg::op_beat_t  op,
  output logic                      res_valid,
  input  wire logic                 res_stall,
  output rvalu_pkg::res_beat_t      res
);

  import rvalu_pkg::*;

  // Execute stage.
  exec_stage_t s1;
  logic        s1_valid;
  logic        s1_adv;

  // Register file: contents in RAM, written-since-reset bits in flops.
  logic [RegCount-1:0]    rf_vld;
  logic [XLen-1:0]        rdata1;
  logic [XLen-1:0]        rdata2;
  logic                   wr_en;
  logic [XLen-1:0]        byp_val;

  logic                   accept;
  logic [XLen-1:0]        opa;
  logic [XLen-1:0]        opb;
  logic [XLen-1:0]        opr2;
  logic [XLen-1:0]        alu_res;
  logic                   alt;
  logic [4:0]             shamt;

  // The execute stage moves on when the result register is free or being drained.
  assign s1_adv   = !res_valid || !res_stall;
  assign op_stall = s1_valid && !s1_adv;
  assign accept   = op_valid && !op_stall;
  assign wr_en    = s1_valid && s1_adv && (s1.op.dest_reg != '0);

  rvalu_ram #(
    .Width (XLen),
    .Depth (RegCount)
  ) u_rf_a (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1.op.dest_reg),
    .wdata (alu_res),
    .re    (accept),
    .raddr (op.src1_reg),
    .rdata (rdata1)
  );

  rvalu_ram #(
    .Width (XLen),
    .Depth (RegCount)
  ) u_rf_b (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1.op.dest_reg),
    .wdata (alu_res),
    .re    (accept),
    .raddr (op.src2_reg),
    .rdata (rdata2)
  );

  // Register zero is never written, so its valid bit stays clear and it reads zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      rf_vld <= '0;
    end else if (wr_en) begin
      rf_vld[s1.op.dest_reg] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // The RAM read happens at the same edge as the write-back of the older
  // instruction, so a matching source takes the ALU result directly.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1.op   <= op;
      s1.vld1 <= rf_vld[op.src1_reg];
      s1.vld2 <= rf_vld[op.src2_reg];
      s1.byp1 <= wr_en && (s1.op.dest_reg == op.src1_reg);
      s1.byp2 <= wr_en && (s1.op.dest_reg == op.src2_reg);
      byp_val <= alu_res;
    end
  end

  always_comb begin
    opa = s1.byp1 ? byp_val : (s1.vld1 ? rdata1 : '0);
    opr2 = s1.byp2 ? byp_val : (s1.vld2 ? rdata2 : '0);
    opb = (form_t'(s1.op.cmd) == FORM_IMM) ? {{(XLen-12){s1.op.imm12[11]}}, s1.op.imm12}
                                           : opr2;
    alt   = (s1.op.func7 == SubSraSel);
    shamt = opb[4:0];
    unique case (alu_op_t'(s1.op.func3))
      F3_ADD:  alu_res = ((form_t'(s1.op.cmd) == FORM_REG) && alt) ? opa - opb : opa + opb;
      F3_SLL:  alu_res = opa << shamt;
      F3_SLT:  alu_res = {{(XLen-1){1'b0}}, ($signed(opa) < $signed(opb))};
      F3_SLTU: alu_res = {{(XLen-1){1'b0}}, (opa < opb)};
      F3_XOR:  alu_res = opa ^ opb;
      F3_SR:   alu_res = alt ? XLen'($signed(opa) >>> shamt) : opa >> shamt;
      F3_OR:   alu_res = opa | opb;
      F3_AND:  alu_res = opa & opb;
      default: alu_res = opa & opb;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      res.write_index <= s1.op.dest_reg;
      res.write_value <= $signed(alu_res);
    end
  end

`ifndef SYNTH
  a_zero_never_valid: assert property (@(posedge clk) disable iff (rst) !rf_vld[0])
    else $error("register zero marked as written");

  a_res_from_stage: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(s1_valid))
    else $error("result appeared without an instruction in execute");

  a_index_follows: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_adv) |=> (res_valid && res.write_index == $past(s1.op.dest_reg)))
    else $error("result index does not match the executed instruction");

  a_bypass_src1: assert property (@(posedge clk) disable iff (rst)
    (accept && wr_en && s1.op.dest_reg == op.src1_reg) |=> (s1_valid && s1.byp1))
    else $error("missed forward of write-back to rs1");

  a_bypass_src2: assert property (@(posedge clk) disable iff (rst)
    (accept && wr_en && s1.op.dest_reg == op.src2_reg) |=> (s1_valid && s1.byp2))
    else $error("missed forward of write-back to rs2");
`endif

endmodule

`default_nettype wire
